// File: sv/assert_macros.svh
// Assertion macros shared by the extractor RTL.
// Each macro expects a signal named clk, and SEISDE_ASSERT also rst_n, in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SEISDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must hold during reset as well.
`define SEISDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/seisde_pkg.sv
// Package for the SEI side-data extractor: widths, codes, GUID tables and types.
// No dependencies; every RTL file of the extractor imports it.
package seisde_pkg;

  localparam int SIZE_BITS  = 16;
  localparam int GUID_BYTES = 16;
  localparam int GIDX_W     = $clog2(GUID_BYTES);
  localparam int POS_W      = 16;

  localparam logic [POS_W-1:0] MIN_FRAME   = 16'd24;
  localparam logic [POS_W-1:0] HDR_TRAILER = 16'd8;
  localparam logic [7:0]       MIN_SIDE    = 8'd17;
  localparam logic [7:0]       NAL_MASK    = 8'h1f;
  localparam logic [7:0]       NAL_SEI     = 8'h06;
  localparam logic [7:0]       PT_UDU      = 8'h05;
  localparam logic [7:0]       SIZE_EXT    = 8'hff;
  localparam logic [7:0]       SC_ZERO     = 8'h00;
  localparam logic [7:0]       SC_ONE      = 8'h01;

  localparam logic [7:0] GUID_SIDE [GUID_BYTES] = '{
    8'hef, 8'hc8, 8'he7, 8'hb0, 8'h26, 8'h26, 8'h47, 8'hfd,
    8'h9d, 8'ha3, 8'h49, 8'h4f, 8'h60, 8'hb8, 8'h5b, 8'hf0};

  localparam logic [7:0] GUID_CURSOR [GUID_BYTES] = '{
    8'h2f, 8'h69, 8'he7, 8'hb0, 8'h16, 8'h56, 8'h87, 8'hfd,
    8'h2d, 8'h14, 8'h26, 8'h37, 8'h14, 8'h22, 8'h23, 8'h38};

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_GUID1,
    PH_SIDE,
    PH_MARK,
    PH_CSIZE,
    PH_GUID2,
    PH_CURSOR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SIDE   = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  localparam logic [3:0] ST_OK_NO_CURSOR = 4'd0;
  localparam logic [3:0] ST_OK_CURSOR    = 4'd1;
  localparam logic [3:0] ST_SHORT        = 4'd2;
  localparam logic [3:0] ST_NO_START     = 4'd3;
  localparam logic [3:0] ST_NOT_SEI5     = 4'd4;
  localparam logic [3:0] ST_BAD_SIZE     = 4'd5;
  localparam logic [3:0] ST_GUID1        = 4'd6;
  localparam logic [3:0] ST_GUID2        = 4'd7;
  localparam logic [3:0] ST_CSIZE_BAD    = 4'd8;
  localparam logic [3:0] ST_TRUNCATED    = 4'd9;

  // Output queue sizing: one accepted byte pushes at most two results.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int MAX_PUSH = 2;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } step_out_t;

endpackage

// File: sv/sei_side_data_extractor.sv
// SEI side-data extractor: one frame byte per transaction in, extracted bytes and status out.
// Results of accepted bytes are registered in the result queue; in_ready drops at 3+ entries.
// Throughput: one byte per cycle while in_ready is high; a byte that ends a frame may yield
// two results, which drain one per cycle while out_ready is high, from a four-entry queue.
// Reset: synchronous active-low rst_n empties the queue and leaves the parser waiting for
// a start of frame; bytes arriving before one are dropped without a result.
module sei_side_data_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_frame,
  input  logic [15:0] in_frame_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_status,
  output logic        out_last
);
  import seisde_pkg::*;

  step_out_t step_out;
  result_t   res;
  logic      space_ok;
  logic      step_en;

  assign in_ready = space_ok;
  assign step_en  = in_valid && space_ok;

  seisde_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .data_byte  (in_data_byte),
    .sof        (in_start_of_frame),
    .frame_len  (in_frame_len),
    .step_out   (step_out)
  );

  seisde_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step_out),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_payload_byte = res.payload_byte;
  assign out_status       = res.status;
  assign out_last         = res.last;

endmodule

// File: sv/seisde_parser.sv
// Byte-level parser state and per-byte update for the SEI side-data extractor.
// Depends on seisde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module seisde_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              data_byte,
  input  logic                    sof,
  input  logic [15:0]             frame_len,
  output seisde_pkg::step_out_t   step_out
);
  import seisde_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [7:0]             side_r, side_nxt;
  logic [SIZE_BITS-1:0]   br_r, br_nxt;
  logic [SIZE_BITS-1:0]   sum_r, sum_nxt;
  logic [POS_W-1:0]       lat_r, lat_nxt;
  logic                   done_r, done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      side_r  <= '0;
      br_r    <= '0;
      sum_r   <= '0;
      lat_r   <= '0;
      done_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      side_r  <= side_nxt;
      br_r    <= br_nxt;
      sum_r   <= sum_nxt;
      lat_r   <= lat_nxt;
      done_r  <= done_nxt;
    end
  end

  phase_t                 ph_e;
  logic [POS_W-1:0]       pos_e;
  logic [7:0]             side_e;
  logic [SIZE_BITS-1:0]   br_e;
  logic [SIZE_BITS-1:0]   sum_e;
  logic [POS_W-1:0]       lat_e;
  logic                   run;
  logic                   short_frame;
  logic                   emit;
  kind_t                  emit_kind;
  logic                   fin;
  logic [3:0]             fin_code;
  logic [SIZE_BITS-1:0]   br_dec;
  logic [SIZE_BITS-1:0]   gdone;
  logic [GIDX_W-1:0]      gidx;
  logic [SIZE_BITS:0]     csum;
  logic [POS_W:0]         pos_inc;
  result_t                byte_res;
  result_t                stat_res;

  always_comb begin
    ph_e        = phase_r;
    pos_e       = pos_r;
    side_e      = side_r;
    br_e        = br_r;
    sum_e       = sum_r;
    lat_e       = lat_r;
    done_nxt    = done_r;
    run         = 1'b0;
    short_frame = 1'b0;

    // A start of frame restarts the parser before the byte itself is parsed.
    if (step_en) begin
      if (sof) begin
        ph_e     = PH_HEADER;
        pos_e    = '0;
        side_e   = '0;
        br_e     = '0;
        sum_e    = '0;
        lat_e    = frame_len;
        done_nxt = 1'b0;
        if (frame_len < MIN_FRAME) begin
          short_frame = 1'b1;
          done_nxt    = 1'b1;
        end else begin
          run = 1'b1;
        end
      end else begin
        run = !done_r;
      end
    end

    phase_nxt = ph_e;
    pos_nxt   = pos_e;
    side_nxt  = side_e;
    br_nxt    = br_e;
    sum_nxt   = sum_e;
    lat_nxt   = lat_e;

    emit      = 1'b0;
    emit_kind = KIND_SIDE;
    fin       = 1'b0;
    fin_code  = ST_OK_NO_CURSOR;
    br_dec    = br_e - SIZE_BITS'(1);
    gdone     = SIZE_BITS'(GUID_BYTES) - br_e;
    gidx      = gdone[GIDX_W-1:0];
    csum      = {1'b0, sum_e} + (SIZE_BITS + 1)'(data_byte);
    pos_inc   = {1'b0, pos_e} + (POS_W + 1)'(1);

    if (run) begin
      case (ph_e)
        PH_HEADER: begin
          if (pos_e <= POS_W'(2)) begin
            if (data_byte != SC_ZERO) begin
              fin = 1'b1; fin_code = ST_NO_START;
            end
          end else if (pos_e == POS_W'(3)) begin
            if (data_byte != SC_ONE) begin
              fin = 1'b1; fin_code = ST_NO_START;
            end
          end else if (pos_e == POS_W'(4)) begin
            if ((data_byte & NAL_MASK) != NAL_SEI) begin
              fin = 1'b1; fin_code = ST_NOT_SEI5;
            end
          end else if (pos_e == POS_W'(5)) begin
            if (data_byte != PT_UDU) begin
              fin = 1'b1; fin_code = ST_NOT_SEI5;
            end
          end else begin
            if ((POS_W'(data_byte) > (lat_e - HDR_TRAILER)) || (data_byte < MIN_SIDE)) begin
              fin = 1'b1; fin_code = ST_BAD_SIZE;
            end else begin
              side_nxt  = data_byte;
              br_nxt    = SIZE_BITS'(GUID_BYTES);
              phase_nxt = PH_GUID1;
            end
          end
        end
        PH_GUID1: begin
          if (data_byte != GUID_SIDE[gidx]) begin
            fin = 1'b1; fin_code = ST_GUID1;
          end else if (br_dec == '0) begin
            br_nxt    = SIZE_BITS'(side_e) - SIZE_BITS'(GUID_BYTES);
            phase_nxt = PH_SIDE;
          end else begin
            br_nxt = br_dec;
          end
        end
        PH_SIDE: begin
          emit      = 1'b1;
          emit_kind = KIND_SIDE;
          if (br_e != '0) begin
            br_nxt = br_dec;
          end
          if (br_e <= SIZE_BITS'(1)) begin
            phase_nxt = PH_MARK;
          end
        end
        PH_MARK: begin
          if (data_byte != PT_UDU) begin
            fin = 1'b1; fin_code = ST_OK_NO_CURSOR;
          end else begin
            sum_nxt   = '0;
            phase_nxt = PH_CSIZE;
          end
        end
        PH_CSIZE: begin
          // Size is a run of 0xFF bytes plus a final byte, summed with overflow check.
          if (csum[SIZE_BITS]) begin
            fin = 1'b1; fin_code = ST_CSIZE_BAD;
          end else begin
            sum_nxt = csum[SIZE_BITS-1:0];
            if (data_byte != SIZE_EXT) begin
              if (csum[SIZE_BITS-1:0] < SIZE_BITS'(GUID_BYTES)) begin
                fin = 1'b1; fin_code = ST_CSIZE_BAD;
              end else begin
                sum_nxt   = csum[SIZE_BITS-1:0] - SIZE_BITS'(GUID_BYTES);
                br_nxt    = SIZE_BITS'(GUID_BYTES);
                phase_nxt = PH_GUID2;
              end
            end
          end
        end
        PH_GUID2: begin
          if (data_byte != GUID_CURSOR[gidx]) begin
            fin = 1'b1; fin_code = ST_GUID2;
          end else if (br_dec == '0) begin
            if (sum_e == '0) begin
              br_nxt = br_dec;
              fin = 1'b1; fin_code = ST_OK_CURSOR;
            end else begin
              br_nxt    = sum_e;
              phase_nxt = PH_CURSOR;
            end
          end else begin
            br_nxt = br_dec;
          end
        end
        default: begin
          emit      = 1'b1;
          emit_kind = KIND_CURSOR;
          if (br_e != '0) begin
            br_nxt = br_dec;
          end
          if (br_e <= SIZE_BITS'(1)) begin
            fin = 1'b1; fin_code = ST_OK_CURSOR;
          end
        end
      endcase

      pos_nxt = pos_inc[POS_W-1:0];
      if (!fin && (pos_inc >= {1'b0, lat_e})) begin
        fin = 1'b1; fin_code = ST_TRUNCATED;
      end
      if (fin) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    byte_res.kind         = emit_kind;
    byte_res.payload_byte = data_byte;
    byte_res.status       = ST_OK_NO_CURSOR;
    byte_res.last         = 1'b0;
    stat_res.kind         = KIND_STATUS;
    stat_res.payload_byte = '0;
    stat_res.status       = short_frame ? ST_SHORT : fin_code;
    stat_res.last         = 1'b1;

    step_out.cnt = 2'd0;
    step_out.r0  = stat_res;
    step_out.r1  = stat_res;
    if (short_frame) begin
      step_out.cnt = 2'd1;
    end else if (run) begin
      if (emit && fin) begin
        step_out.cnt = 2'd2;
        step_out.r0  = byte_res;
      end else if (emit) begin
        step_out.cnt = 2'd1;
        step_out.r0  = byte_res;
      end else if (fin) begin
        step_out.cnt = 2'd1;
      end
    end
  end

  `SEISDE_ASSERT(a_pair_ends_in_status,
    (step_out.cnt == 2'd2) |-> (step_out.r0.kind != KIND_STATUS &&
      step_out.r1.kind == KIND_STATUS && step_out.r1.last),
    "two results must be a byte followed by the final status")
  `SEISDE_ASSERT(a_status_closes_frame, (step_en && (fin || short_frame)) |=> done_r,
    "frame must be closed after its status item")
  `SEISDE_ASSERT(a_idle_holds_phase, !step_en |=> $stable(phase_r),
    "parser phase changed without an accepted byte")

endmodule

// File: sv/seisde_outq.sv
// Small result queue: takes up to two results per cycle, hands out one per cycle when out_ready.
// Depends on seisde_pkg and assert_macros.svh.
`include "assert_macros.svh"

module seisde_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  seisde_pkg::step_out_t push,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output seisde_pkg::result_t   out_res
);
  import seisde_pkg::*;

  result_t              mem [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]    count_r, count_nxt;
  logic                 pop;
  logic [QPTR_W-1:0]    wr_ptr_p1;

  // Room for a full two-result push is required before a byte is taken.
  assign space_ok  = count_r <= QCNT_W'(QDEPTH - MAX_PUSH);
  assign out_valid = count_r != '0;
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  `SEISDE_ASSERT(a_count_bound, count_r <= QCNT_W'(QDEPTH), "queue count above depth")
  `SEISDE_ASSERT(a_push_has_room, (push.cnt != 2'd0) |-> space_ok,
    "results pushed into a queue without room")
  `SEISDE_ASSERT(a_pop_only_drains,
    (pop && push.cnt == 2'd0) |=> (count_r == $past(count_r) - QCNT_W'(1)),
    "pop without push must drain one entry")

endmodule

// File: dv/tb.sv
// Self-checking testbench for sei_side_data_extractor: directed frames, then random frames.
// Depends on seisde_pkg for result types, phases, GUID tables and status codes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import seisde_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          ITEM_TARGET    = 1050;
  localparam int          MAX_REPORTS    = 10;
  localparam int unsigned SUM_MAX        = (2 ** SIZE_BITS) - 1;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_start_of_frame;
  logic [15:0] in_frame_len;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [3:0]  out_status;
  logic        out_last;

  result_t pending_results[$];
  int      mismatches;
  int      idle_cycles;
  int      bytes_sent;
  bit      src_idle  = 1'b1;
  bit      sink_idle = 1'b1;

  // Parser state as the predictor sees it.
  phase_t      pr_phase;
  int unsigned pr_pos;
  logic [7:0]  pr_side_size;
  int unsigned pr_remaining;
  int unsigned pr_csum;
  logic [15:0] pr_fsize;
  bit          pr_done;

  sei_side_data_extractor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_start_of_frame(in_start_of_frame),
    .in_frame_len     (in_frame_len),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  function automatic void push_result(input kind_t k, input logic [7:0] pb,
                                      input logic [3:0] st, input logic lst);
    result_t r;
    r.kind         = k;
    r.payload_byte = pb;
    r.status       = st;
    r.last         = lst;
    pending_results = {pending_results, r};
  endfunction

  // Advances the parser state by one accepted byte and queues what it yields.
  function automatic void predict_extraction(input logic [7:0] b, input logic sof,
                                             input logic [15:0] fs);
    logic [3:0]  fin;
    bit          has_fin;
    int unsigned gidx;
    fin     = ST_OK_NO_CURSOR;
    has_fin = 1'b0;
    if (sof) begin
      pr_phase     = PH_HEADER;
      pr_pos       = 0;
      pr_side_size = 8'd0;
      pr_remaining = 0;
      pr_csum      = 0;
      pr_fsize     = fs;
      pr_done      = 1'b0;
      if (fs < MIN_FRAME) begin
        pr_done = 1'b1;
        push_result(KIND_STATUS, 8'd0, ST_SHORT, 1'b1);
        return;
      end
    end else if (pr_done) begin
      return;
    end

    gidx = (GUID_BYTES - pr_remaining) % GUID_BYTES;
    case (pr_phase)
      PH_HEADER: begin
        if (pr_pos <= 2) begin
          if (b != SC_ZERO) begin has_fin = 1'b1; fin = ST_NO_START; end
        end else if (pr_pos == 3) begin
          if (b != SC_ONE) begin has_fin = 1'b1; fin = ST_NO_START; end
        end else if (pr_pos == 4) begin
          if ((b & NAL_MASK) != NAL_SEI) begin has_fin = 1'b1; fin = ST_NOT_SEI5; end
        end else if (pr_pos == 5) begin
          if (b != PT_UDU) begin has_fin = 1'b1; fin = ST_NOT_SEI5; end
        end else begin
          if (int'(b) > int'(pr_fsize) - int'(HDR_TRAILER) || b < MIN_SIDE) begin
            has_fin = 1'b1;
            fin     = ST_BAD_SIZE;
          end else begin
            pr_side_size = b;
            pr_remaining = GUID_BYTES;
            pr_phase     = PH_GUID1;
          end
        end
      end
      PH_GUID1: begin
        if (b != GUID_SIDE[gidx]) begin
          has_fin = 1'b1;
          fin     = ST_GUID1;
        end else begin
          pr_remaining--;
          if (pr_remaining == 0) begin
            pr_remaining = int'(pr_side_size) - GUID_BYTES;
            pr_phase     = PH_SIDE;
          end
        end
      end
      PH_SIDE: begin
        push_result(KIND_SIDE, b, 4'd0, 1'b0);
        if (pr_remaining > 0) pr_remaining--;
        if (pr_remaining == 0) pr_phase = PH_MARK;
      end
      PH_MARK: begin
        if (b != PT_UDU) begin
          has_fin = 1'b1;
          fin     = ST_OK_NO_CURSOR;
        end else begin
          pr_csum  = 0;
          pr_phase = PH_CSIZE;
        end
      end
      PH_CSIZE: begin
        if (pr_csum + b > SUM_MAX) begin
          has_fin = 1'b1;
          fin     = ST_CSIZE_BAD;
        end else begin
          pr_csum += b;
          if (b != SIZE_EXT) begin
            if (pr_csum < GUID_BYTES) begin
              has_fin = 1'b1;
              fin     = ST_CSIZE_BAD;
            end else begin
              pr_csum      -= GUID_BYTES;
              pr_remaining = GUID_BYTES;
              pr_phase     = PH_GUID2;
            end
          end
        end
      end
      PH_GUID2: begin
        if (b != GUID_CURSOR[gidx]) begin
          has_fin = 1'b1;
          fin     = ST_GUID2;
        end else begin
          pr_remaining--;
          if (pr_remaining == 0) begin
            if (pr_csum == 0) begin
              has_fin = 1'b1;
              fin     = ST_OK_CURSOR;
            end else begin
              pr_remaining = pr_csum;
              pr_phase     = PH_CURSOR;
            end
          end
        end
      end
      default: begin
        push_result(KIND_CURSOR, b, 4'd0, 1'b0);
        if (pr_remaining > 0) pr_remaining--;
        if (pr_remaining == 0) begin
          has_fin = 1'b1;
          fin     = ST_OK_CURSOR;
        end
      end
    endcase

    pr_pos++;
    if (!has_fin && pr_pos >= pr_fsize) begin
      has_fin = 1'b1;
      fin     = ST_TRUNCATED;
    end
    if (has_fin) begin
      pr_done = 1'b1;
      push_result(KIND_STATUS, 8'd0, fin, 1'b1);
    end
  endfunction

  // Builds a well-formed frame; cur_len below zero means no cursor payload.
  function automatic void make_frame(output byte_q_t fr, input int side_len, input int cur_len);
    int v;
    fr = {};
    repeat (3) fr = {fr, SC_ZERO};
    fr = {fr, SC_ONE};
    fr = {fr, {3'($urandom_range(0, 7)), NAL_SEI[4:0]}};
    fr = {fr, PT_UDU};
    fr = {fr, 8'(side_len)};
    for (int i = 0; i < GUID_BYTES; i++) fr = {fr, GUID_SIDE[i]};
    repeat (side_len - GUID_BYTES) fr = {fr, 8'($urandom_range(0, 255))};
    if (cur_len < 0) begin
      do v = $urandom_range(0, 255); while (v == PT_UDU);
      fr = {fr, 8'(v)};
    end else begin
      fr = {fr, PT_UDU};
      // The size is coded as a run of 0xFF bytes and a final byte below 0xFF.
      v = cur_len + GUID_BYTES;
      while (v >= 255) begin
        fr = {fr, SIZE_EXT};
        v -= 255;
      end
      fr = {fr, 8'(v)};
      for (int i = 0; i < GUID_BYTES; i++) fr = {fr, GUID_CURSOR[i]};
      repeat (cur_len) fr = {fr, 8'($urandom_range(0, 255))};
    end
  endfunction

  // Drives one byte transaction and waits until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic [15:0] fs);
    int gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_start_of_frame <= sof;
    in_frame_len      <= fs;
    do @(posedge clk); while (!in_ready);
    predict_extraction(b, sof, fs);
    bytes_sent++;
  endtask

  // Sends the first n bytes of a frame, all of them when n is negative.
  task automatic send_frame(input byte_q_t fr, input logic [15:0] fs, input int n);
    int cnt;
    cnt = (n < 0 || n > fr.size()) ? fr.size() : n;
    for (int i = 0; i < cnt; i++) begin
      send_byte(fr[i], i == 0, fs);
    end
  endtask

  task automatic test_ignored_bytes();
    // Nothing is open after reset, so these bytes must vanish.
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_short_frame();
    send_byte(8'h00, 1'b1, 16'd0);
    send_byte(8'hff, 1'b1, 16'd23);
    send_byte(8'h00, 1'b0, 16'd23);
  endtask

  task automatic test_start_code();
    byte_q_t fr;
    for (int i = 0; i < 4; i++) begin
      make_frame(fr, 17, -1);
      fr[i] = (i == 3) ? 8'h00 : 8'h01;
      send_frame(fr, 16'(fr.size()), i + 1);
    end
  endtask

  task automatic test_sei_type();
    byte_q_t fr;
    make_frame(fr, 17, -1);
    fr[4] = 8'he7;
    send_frame(fr, 16'(fr.size()), 5);
    make_frame(fr, 17, -1);
    fr[5] = 8'h04;
    send_frame(fr, 16'(fr.size()), 6);
  endtask

  task automatic test_payload_size();
    byte_q_t fr;
    make_frame(fr, 17, -1);
    fr[6] = 8'd16;
    send_frame(fr, 16'(fr.size()), 7);
    make_frame(fr, 17, -1);
    fr[6] = 8'(fr.size() - 7);
    send_frame(fr, 16'(fr.size()), 7);
  endtask

  task automatic test_side_guid();
    byte_q_t fr;
    int idx;
    make_frame(fr, 17, -1);
    idx     = 7 + $urandom_range(0, GUID_BYTES - 1);
    fr[idx] = fr[idx] ^ 8'h80;
    send_frame(fr, 16'(fr.size()), idx + 1);
  endtask

  task automatic test_side_data();
    byte_q_t fr;
    // Side payload at the largest size the frame allows, extreme byte values inside.
    make_frame(fr, 20, -1);
    fr[23] = 8'h00;
    fr[26] = 8'hff;
    send_frame(fr, 16'(fr.size()), -1);
  endtask

  task automatic test_cursor_data();
    byte_q_t fr;
    make_frame(fr, 18, 4);
    fr[fr.size() - 1] = 8'hff;
    send_frame(fr, 16'(fr.size()), -1);
    // A cursor size of exactly one GUID carries no cursor bytes.
    make_frame(fr, 17, 0);
    send_frame(fr, 16'(fr.size()), -1);
  endtask

  task automatic test_cursor_size();
    byte_q_t fr;
    make_frame(fr, 17, -1);
    void'(fr.pop_back());
    fr = {fr, PT_UDU};
    fr = {fr, 8'h0f};
    send_frame(fr, 16'(fr.size()), -1);
    // A long run of extension bytes and a final byte overflow the size accumulator.
    make_frame(fr, 17, -1);
    void'(fr.pop_back());
    fr = {fr, PT_UDU};
    repeat (257) fr = {fr, SIZE_EXT};
    fr = {fr, 8'h01};
    send_frame(fr, 16'hffff, -1);
  endtask

  task automatic test_cursor_guid();
    byte_q_t fr;
    int idx;
    make_frame(fr, 17, 3);
    idx     = 26 + $urandom_range(0, GUID_BYTES - 1);
    fr[idx] = fr[idx] ^ 8'h01;
    send_frame(fr, 16'(fr.size()), idx + 1);
  endtask

  task automatic test_truncation();
    byte_q_t fr;
    // The frame ends on the last side byte: a side byte and then the truncation status.
    make_frame(fr, 17, -1);
    send_frame(fr, 16'd24, -1);
    make_frame(fr, 17, 5);
    send_frame(fr, 16'(fr.size() - 2), -1);
  endtask

  task automatic test_restart();
    byte_q_t fr;
    make_frame(fr, 19, 2);
    send_frame(fr, 16'(fr.size()), 24);
    make_frame(fr, 17, 1);
    send_frame(fr, 16'(fr.size()), -1);
  endtask

  // Random frames fill up the run until the overall byte count is reached.
  task automatic test_random_frames();
    byte_q_t fr;
    int side_len;
    int cur_len;
    int sel;
    int fs;
    int idx;
    while (bytes_sent < ITEM_TARGET) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      side_len  = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 255) : $urandom_range(17, 24);
      sel = $urandom_range(0, 24);
      if (sel < 7)       cur_len = -1;
      else if (sel < 10) cur_len = 0;
      else if (sel == 10) cur_len = $urandom_range(235, 260);
      else               cur_len = $urandom_range(1, 8);
      make_frame(fr, side_len, cur_len);
      sel = $urandom_range(0, 9);
      fs  = fr.size();
      if (sel <= 5) begin
        case ($urandom_range(0, 9))
          0, 1:    fs = fr.size() + $urandom_range(1, 100);
          2:       fs = $urandom_range(fr.size(), 65535);
          default: fs = fr.size();
        endcase
        send_frame(fr, 16'(fs), -1);
      end else if (sel == 6) begin
        idx     = $urandom_range(0, fr.size() - 1);
        fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
        send_frame(fr, 16'(fs), -1);
      end else if (sel == 7) begin
        send_frame(fr, 16'($urandom_range(24, fr.size() - 1)), -1);
      end else if (sel == 8) begin
        send_frame(fr, 16'(fs), $urandom_range(1, fr.size() - 1));
      end else begin
        send_frame(fr, 16'($urandom_range(0, 23)), $urandom_range(1, 3));
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)), 1'b0, 16'(fs));
      end
    end
  endtask

  // Result side: a fresh stall length for every result transaction.
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d byte %02h status %0d last %0d",
                   out_kind, out_payload_byte, out_status, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind || out_payload_byte !== want.payload_byte ||
            out_status !== want.status || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: expected kind %0d byte %02h status %0d last %0d, ",
                      "got kind %0d byte %02h status %0d last %0d"},
                     want.kind, want.payload_byte, want.status, want.last,
                     out_kind, out_payload_byte, out_status, out_last);
        end
      end
    end
  end

  // Ends the run if no transaction happens on either side for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin : main
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_data_byte      = 8'd0;
    in_start_of_frame = 1'b0;
    in_frame_len      = 16'd0;
    bytes_sent        = 0;
    pr_phase          = PH_HEADER;
    pr_pos            = 0;
    pr_side_size      = 8'd0;
    pr_remaining      = 0;
    pr_csum           = 0;
    pr_fsize          = 16'd0;
    pr_done           = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ignored_bytes();
    test_short_frame();
    test_start_code();
    test_sei_type();
    test_payload_size();
    test_side_guid();
    test_side_data();
    test_cursor_data();
    test_cursor_size();
    test_cursor_guid();
    test_truncation();
    test_restart();
    test_random_frames();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/seisde_pkg.sv
sv/seisde_parser.sv
sv/seisde_outq.sv
sv/sei_side_data_extractor.sv
dv/tb.sv
